// ===== sv/ffpa_pkg.sv =====
// Shared types and constants for the first-fit partition allocator.
`default_nettype none

package ffpa_pkg;

  // Fixed field widths of the input and result beats
  localparam int CMD_W      = 2;
  localparam int BIDX_W     = 4;
  localparam int SIZE_IN_W  = 16;
  localparam int JOB_W      = 16;
  localparam int SUM_W      = 20;
  localparam int CFG_W      = 5;

  // Defaults for the top-level parameters
  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Saturation limit of both running totals
  localparam logic [SUM_W-1:0] SUM_MAX = 20'hFFFFF;

  // Reset value of the search limit register
  localparam logic [CFG_W-1:0] BLOCKS_IN_USE_RST = 5'd16;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [BIDX_W-1:0]    block_index;
    logic [SIZE_IN_W-1:0] size;
  } in_item_t;

  typedef struct packed {
    logic                 granted;
    logic [BIDX_W-1:0]    granted_block;
    logic [JOB_W-1:0]     job_id;
    logic [SIZE_IN_W-1:0] leftover;
    logic [SUM_W-1:0]     total_used;
    logic [SUM_W-1:0]     total_loaded;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;   // capture the input beat and arm the scan
    logic scan;     // advance the partition scan by one step
    logic commit;   // apply the command and load the result register
  } ffpa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_alloc;   // the offered beat is an allocate
    logic scan_done;  // the scan found a fit or ran out of partitions
    logic out_free;   // the result register can take a new beat
  } ffpa_stat_t;

endpackage

`default_nettype wire

// ===== sv/ffpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ffpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/ffpa_datapath.sv =====
// Datapath: partition table, scan pipeline, running totals and result register.
`default_nettype none

module ffpa_datapath
  import ffpa_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire in_item_t         in_item,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire ffpa_cmd_t        ctl,
  output ffpa_stat_t            sts,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_item
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int LIM_W = $clog2(NUM_BLOCKS + 1);
  localparam int ADD_W = ((SIZE_BITS > SUM_W) ? SIZE_BITS : SUM_W) + 1;

  // Configuration and captured command
  logic [CFG_W-1:0]     blocks_in_use;
  logic [CMD_W-1:0]     cmd_q;
  logic [BIDX_W-1:0]    idx_q;
  logic [SIZE_BITS-1:0] sz_q;
  logic [LIM_W-1:0]     limit_q;
  logic [LIM_W-1:0]     limit_in;

  // Partition table flags
  logic [NUM_BLOCKS-1:0] busy;
  logic [NUM_BLOCKS-1:0] size_valid;

  // Scan pipeline
  logic [LIM_W-1:0]     issue_idx;
  logic                 issue_ok;
  logic                 chk_valid;
  logic [IDX_W-1:0]     chk_idx;
  logic [SIZE_BITS-1:0] rdata;
  logic [SIZE_BITS-1:0] part_sz;
  logic                 hit;
  logic                 hit_found;
  logic [IDX_W-1:0]     hit_idx;
  logic [SIZE_BITS-1:0] hit_left;

  // Counters
  logic [JOB_W-1:0] job_counter;
  logic [JOB_W-1:0] job_counter_next;
  logic [SUM_W-1:0] used_sum;
  logic [SUM_W-1:0] used_sum_next;
  logic [SUM_W-1:0] available_sum;
  logic [SUM_W-1:0] available_sum_next;
  logic [ADD_W-1:0] used_add;
  logic [ADD_W-1:0] avail_add;
  logic [SUM_W-1:0] used_sat;
  logic [SUM_W-1:0] avail_sat;

  // Load decode
  logic             idx_ok;
  logic [IDX_W-1:0] load_addr;
  logic             ram_we;

  // Search limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= BLOCKS_IN_USE_RST;
    end else if (cfg_we) begin
      blocks_in_use <= cfg_data;
    end
  end

  // Clamp the search limit to the table depth
  always_comb begin
    if (int'(blocks_in_use) > NUM_BLOCKS) begin
      limit_in = LIM_W'(NUM_BLOCKS);
    end else begin
      limit_in = LIM_W'(blocks_in_use);
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_q   <= in_item.cmd;
      idx_q   <= in_item.block_index;
      sz_q    <= SIZE_BITS'(in_item.size);
      limit_q <= limit_in;
    end
  end

  // Status to the controller
  assign issue_ok      = issue_idx < limit_q;
  assign sts.is_alloc  = in_item.cmd == CMD_ALLOC;
  assign sts.scan_done = (chk_valid && hit) || (!chk_valid && !issue_ok);
  assign sts.out_free  = !out_valid || !out_stall;

  // Size memory, one partition read per cycle during the scan
  assign idx_ok    = int'(idx_q) < NUM_BLOCKS;
  assign load_addr = IDX_W'(idx_q);
  assign ram_we    = ctl.commit && (cmd_q == CMD_LOAD) && idx_ok;

  ffpa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_BLOCKS)
  ) u_size_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (load_addr),
    .wdata (sz_q),
    .raddr (issue_idx[IDX_W-1:0]),
    .rdata (rdata)
  );

  // Check the entry read in the previous cycle; unloaded entries read as zero
  assign part_sz = size_valid[chk_idx] ? rdata : '0;
  assign hit     = !busy[chk_idx] && (sz_q <= part_sz);

  // Advance the scan pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_idx <= '0;
      chk_valid <= 1'b0;
      hit_found <= 1'b0;
    end else if (ctl.accept) begin
      issue_idx <= '0;
      chk_valid <= 1'b0;
      hit_found <= 1'b0;
    end else if (ctl.scan) begin
      chk_valid <= issue_ok;
      if (issue_ok) begin
        issue_idx <= issue_idx + 1'b1;
      end
      if (chk_valid && hit) begin
        hit_found <= 1'b1;
      end
    end
  end

  // Hold the index of the entry in the check stage and the first fit
  always_ff @(posedge clk) begin
    if (ctl.scan) begin
      chk_idx <= issue_idx[IDX_W-1:0];
      if (chk_valid && hit) begin
        hit_idx  <= chk_idx;
        hit_left <= part_sz - sz_q;
      end
    end
  end

  // Saturating adds for the totals
  assign used_add  = ADD_W'(used_sum) + ADD_W'(sz_q);
  assign avail_add = ADD_W'(available_sum) + ADD_W'(sz_q);
  assign used_sat  = (used_add > ADD_W'(SUM_MAX)) ? SUM_MAX : used_add[SUM_W-1:0];
  assign avail_sat = (avail_add > ADD_W'(SUM_MAX)) ? SUM_MAX : avail_add[SUM_W-1:0];

  // Next values of the counters at commit
  always_comb begin
    job_counter_next   = job_counter;
    used_sum_next      = used_sum;
    available_sum_next = available_sum;
    if (ctl.commit) begin
      unique case (cmd_q)
        CMD_LOAD: begin
          if (idx_ok) begin
            available_sum_next = avail_sat;
          end
        end
        CMD_ALLOC: begin
          job_counter_next = job_counter + 1'b1;
          if (hit_found) begin
            used_sum_next = used_sat;
          end
        end
        CMD_CLEAR: begin
          job_counter_next   = '0;
          used_sum_next      = '0;
          available_sum_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_counter   <= '0;
      used_sum      <= '0;
      available_sum <= '0;
    end else begin
      job_counter   <= job_counter_next;
      used_sum      <= used_sum_next;
      available_sum <= available_sum_next;
    end
  end

  // Update the busy and loaded flags at commit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= '0;
      size_valid <= '0;
    end else if (ctl.commit) begin
      unique case (cmd_q)
        CMD_LOAD: begin
          if (idx_ok) begin
            busy[load_addr]       <= 1'b0;
            size_valid[load_addr] <= 1'b1;
          end
        end
        CMD_ALLOC: begin
          if (hit_found) begin
            busy[hit_idx] <= 1'b1;
          end
        end
        CMD_CLEAR: begin
          busy <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register: load at commit, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_item.granted       <= (cmd_q == CMD_ALLOC) && hit_found;
      out_item.granted_block <= ((cmd_q == CMD_ALLOC) && hit_found) ?
                                BIDX_W'(hit_idx) : '0;
      out_item.job_id        <= (cmd_q == CMD_ALLOC) ? job_counter : job_counter_next;
      out_item.leftover      <= ((cmd_q == CMD_ALLOC) && hit_found) ?
                                SIZE_IN_W'(hit_left) : '0;
      out_item.total_used    <= used_sum_next;
      out_item.total_loaded  <= available_sum_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ffpa_ctrl.sv =====
// Controller state machine: accept, scan and commit sequencing.
`default_nettype none

module ffpa_ctrl
  import ffpa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  output ffpa_cmd_t       ctl,
  input  wire ffpa_stat_t sts
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          state_next = sts.is_alloc ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          ctl.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Take a new beat only between commands
  assign in_stall = state != ST_IDLE;

endmodule

`default_nettype wire

// ===== sv/first_fit_partition_allocator_unit.sv =====
// Top level of the first-fit fixed-partition allocator.
`default_nettype none

// First-fit allocator over a table of NUM_BLOCKS fixed partitions. Load (cmd 0)
// writes a partition size and frees it, allocate (cmd 1) grants the lowest free
// partition of the first blocks_in_use whose size covers the job, clear (cmd 2)
// frees all partitions and zeroes the job counter and totals; every command gives
// one result beat. Commands are handled one at a time. A load, clear or unused
// code skips the scan; an allocate scans the partitions in order and stops at
// the first fit or after the last searched partition, since the size memory is
// read through one port, one partition per cycle. Results wait in an output
// register, so a stalled result holds off only the commit of the following
// command. There is no clearing pass after reset.

module first_fit_partition_allocator_unit
  import ffpa_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_item,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_item,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_data
);

  ffpa_cmd_t  ctl;
  ffpa_stat_t sts;

  ffpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .ctl      (ctl),
    .sts      (sts)
  );

  ffpa_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // One command in flight: an accepted beat closes the input
  a_accept_closes_input: assert property (
    @(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall
  ) else $error("input left open after an accepted beat");

  // A result that is not a grant names no partition and no leftover
  a_no_grant_is_zero: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && !out_item.granted) |->
      (out_item.granted_block == '0 && out_item.leftover == '0)
  ) else $error("non-granted result carries a partition or leftover");

  // A new result beat appears only as the current command completes
  a_result_on_commit: assert property (
    @(posedge clk) disable iff (rst)
    (in_stall && !out_valid) |=> (!out_valid || !in_stall)
  ) else $error("result beat appeared without a command completing");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the first-fit partition allocator unit.
`timescale 1ns / 100ps

module tb_top;
  import ffpa_pkg::*;

  localparam int NUM_PART    = NUM_BLOCKS_DEF;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_BEATS = 104;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE_CYC  = 30;

  // Spare command code: the block must leave all state alone
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct {
    bit        pinned;
    out_item_t want;
  } typed_t;

  typedef struct {
    in_item_t  stim;
    bit        pinned;
    out_item_t want;
  } row_t;

  logic             clk;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_item   = '0;
  logic             out_valid;
  logic             out_stall = 1'b1;
  out_item_t        out_item;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_data  = '0;

  // Allocator image kept by the scoreboard
  logic [SIZE_IN_W-1:0] part_size [NUM_PART];
  bit                   part_busy [NUM_PART];
  logic [JOB_W-1:0]     job_cnt;
  logic [SUM_W-1:0]     used_total;
  logic [SUM_W-1:0]     avail_total;
  logic [CFG_W-1:0]     search_limit;

  typed_t    typed_q [$];
  out_item_t pending_results [$];
  row_t      dir_rows [$];

  bit gaps_on  = 1'b1;
  bit hold_req = 1'b0;
  int err_count   = 0;
  int beats_total = 0;
  int alloc_total = 0;
  int grant_total = 0;
  int limits_run  = 0;

  first_fit_partition_allocator_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [SUM_W-1:0] sat_total(logic [SUM_W-1:0] acc,
                                                 logic [SIZE_IN_W-1:0] v);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + v;
    return (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  // Apply one command to the image and return the result beat it must give
  function automatic out_item_t alloc_model_step(in_item_t it);
    out_item_t r;
    int lim;
    bit hit;
    r = '0;
    r.job_id = job_cnt;
    case (it.cmd)
      CMD_LOAD: begin
        part_size[it.block_index] = it.size;
        part_busy[it.block_index] = 1'b0;
        avail_total = sat_total(avail_total, it.size);
      end
      CMD_ALLOC: begin
        lim = int'(search_limit);
        if (lim > NUM_PART) lim = NUM_PART;
        hit = 1'b0;
        for (int j = 0; j < lim; j++) begin
          if (!hit && !part_busy[j] && it.size <= part_size[j]) begin
            hit = 1'b1;
            part_busy[j] = 1'b1;
            r.granted = 1'b1;
            r.granted_block = BIDX_W'(j);
            r.leftover = part_size[j] - it.size;
            used_total = sat_total(used_total, it.size);
          end
        end
        job_cnt = job_cnt + 1'b1;
      end
      CMD_CLEAR: begin
        foreach (part_busy[j]) part_busy[j] = 1'b0;
        job_cnt = '0;
        used_total = '0;
        avail_total = '0;
      end
      default: ;
    endcase
    if (it.cmd != CMD_ALLOC) r.job_id = job_cnt;
    r.total_used = used_total;
    r.total_loaded = avail_total;
    return r;
  endfunction

  // Draw a random command; heavy mode skips clears and spare codes and favors big sizes
  function automatic in_item_t make_beat(bit heavy);
    in_item_t it;
    int pick;
    logic [SIZE_IN_W-1:0] pk;
    it.block_index = BIDX_W'($urandom_range(0, NUM_PART - 1));
    pick = $urandom_range(0, 99);
    if (heavy) it.cmd = (pick < 45) ? CMD_LOAD : CMD_ALLOC;
    else if (pick < 40) it.cmd = CMD_LOAD;
    else if (pick < 94) it.cmd = CMD_ALLOC;
    else if (pick < 97) it.cmd = CMD_CLEAR;
    else it.cmd = CMD_SPARE;
    pk = part_size[BIDX_W'($urandom_range(0, NUM_PART - 1))];
    case ($urandom_range(0, 7))
      0: it.size = '0;
      1: it.size = '1;
      2: it.size = pk;
      3: it.size = pk - SIZE_IN_W'($urandom_range(0, 2));
      4: it.size = pk + 1'b1;
      default: it.size = heavy ? SIZE_IN_W'($urandom_range(16'hC000, 16'hFFFF))
                               : SIZE_IN_W'($urandom);
    endcase
    return it;
  endfunction

  function automatic void compare_fields(out_item_t w, out_item_t g);
    if (g.granted !== w.granted) begin
      $error("granted: expected %0d, actual %0d", w.granted, g.granted);
      err_count++;
    end
    if (g.granted_block !== w.granted_block) begin
      $error("granted_block: expected %0d, actual %0d", w.granted_block, g.granted_block);
      err_count++;
    end
    if (g.job_id !== w.job_id) begin
      $error("job_id: expected %0d, actual %0d", w.job_id, g.job_id);
      err_count++;
    end
    if (g.leftover !== w.leftover) begin
      $error("leftover: expected %0d, actual %0d", w.leftover, g.leftover);
      err_count++;
    end
    if (g.total_used !== w.total_used) begin
      $error("total_used: expected %0d, actual %0d", w.total_used, g.total_used);
      err_count++;
    end
    if (g.total_loaded !== w.total_loaded) begin
      $error("total_loaded: expected %0d, actual %0d",
             w.total_loaded, g.total_loaded);
      err_count++;
    end
  endfunction

  // Track config writes and input beats, check every result beat in order
  always @(posedge clk) begin : scoreboard
    out_item_t pred;
    typed_t tag;
    if (rst) begin
      foreach (part_size[j]) begin
        part_size[j] = '0;
        part_busy[j] = 1'b0;
      end
      job_cnt = '0;
      used_total = '0;
      avail_total = '0;
      search_limit = BLOCKS_IN_USE_RST;
    end else begin
      if (cfg_we) search_limit = cfg_data;
      if (in_valid && !in_stall) begin
        pred = alloc_model_step(in_item);
        tag = typed_q.pop_front();
        pending_results.push_back(tag.pinned ? tag.want : pred);
        beats_total++;
        if (in_item.cmd == CMD_ALLOC) alloc_total++;
        grant_total += int'(pred.granted);
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected: %p", out_item);
          err_count++;
        end else begin
          compare_fields(pending_results.pop_front(), out_item);
        end
      end
    end
  end

  // Result side: random stall bursts, plus one long hold on request
  initial begin : result_sink
    int n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 17);
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Offer one beat, maybe after a gap, and return at the edge that takes it
  task automatic offer_beat(input in_item_t it, input bit pinned, input out_item_t want);
    int n;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 17);
      repeat (n) @(posedge clk);
    end
    typed_q.push_back(typed_t'{pinned, want});
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold until every offered beat has come back as a result
  task automatic wait_drained();
    while (typed_q.size() != 0 || pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_search_limit(input logic [CFG_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    limits_run++;
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] limit_plan [NUM_PHASES];
    logic [CFG_W-1:0] lim;
    in_item_t beat;
    bit heavy;
    limit_plan = '{5'd31, 5'd0, 5'd1, 5'd17, 5'd16, 5'd3, 5'd0, 5'd0};
    // Row fields: command, block index, size, pinned flag, then granted, block, job, leftover, used, available
    dir_rows = '{
      '{'{CMD_SPARE, 4'd15, 16'hFFFF}, 1'b1, '{1'b0, 4'd0, 16'd0, 16'd0, 20'd0, 20'd0}},
      '{'{CMD_CLEAR, 4'd0,  16'h0000}, 1'b1, '{1'b0, 4'd0, 16'd0, 16'd0, 20'd0, 20'd0}},
      '{'{CMD_ALLOC, 4'd9,  16'h0000}, 1'b1, '{1'b1, 4'd0, 16'd0, 16'd0, 20'd0, 20'd0}},
      '{'{CMD_LOAD,  4'd15, 16'hFFFF}, 1'b1,
        '{1'b0, 4'd0, 16'd1, 16'd0, 20'd0, 20'h0FFFF}},
      '{'{CMD_LOAD,  4'd0,  16'hFFFF}, 1'b1,
        '{1'b0, 4'd0, 16'd1, 16'd0, 20'd0, 20'h1FFFE}},
      '{'{CMD_ALLOC, 4'd0,  16'hFFFF}, 1'b1,
        '{1'b1, 4'd0, 16'd1, 16'd0, 20'h0FFFF, 20'h1FFFE}},
      '{'{CMD_ALLOC, 4'd0,  16'h0001}, 1'b1,
        '{1'b1, 4'd15, 16'd2, 16'hFFFE, 20'h10000, 20'h1FFFE}},
      '{'{CMD_ALLOC, 4'd6,  16'h0001}, 1'b1,
        '{1'b0, 4'd0, 16'd3, 16'd0, 20'h10000, 20'h1FFFE}},
      '{'{CMD_LOAD,  4'd5,  16'd1000}, 1'b0, '0},
      '{'{CMD_ALLOC, 4'd0,  16'd999},  1'b0, '0},
      '{'{CMD_LOAD,  4'd15, 16'hFFFF}, 1'b0, '0},
      '{'{CMD_LOAD,  4'd1,  16'hFFFF}, 1'b0, '0},
      '{'{CMD_LOAD,  4'd2,  16'hFFFF}, 1'b0, '0},
      '{'{CMD_LOAD,  4'd3,  16'hFFFF}, 1'b0, '0},
      '{'{CMD_LOAD,  4'd4,  16'hFFFF}, 1'b0, '0},
      '{'{CMD_LOAD,  4'd5,  16'hFFFF}, 1'b0, '0},
      '{'{CMD_LOAD,  4'd6,  16'hFFFF}, 1'b0, '0},
      '{'{CMD_LOAD,  4'd7,  16'hFFFF}, 1'b0, '0},
      '{'{CMD_LOAD,  4'd8,  16'hFFFF}, 1'b0, '0},
      '{'{CMD_LOAD,  4'd9,  16'hFFFF}, 1'b0, '0},
      '{'{CMD_LOAD,  4'd10, 16'hFFFF}, 1'b0, '0},
      '{'{CMD_LOAD,  4'd11, 16'hFFFF}, 1'b0, '0},
      '{'{CMD_LOAD,  4'd12, 16'hFFFF}, 1'b0, '0},
      '{'{CMD_LOAD,  4'd13, 16'hFFFF}, 1'b0, '0},
      '{'{CMD_ALLOC, 4'd3,  16'hFFFF}, 1'b0, '0}
    };

    // Hold reset, then release it once
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table with the reset search limit
    foreach (dir_rows[i]) offer_beat(dir_rows[i].stim, dir_rows[i].pinned, dir_rows[i].want);
    in_valid <= 1'b0;
    wait_drained();

    // Random phases, one search limit each, written while the block is idle
    for (int p = 0; p < NUM_PHASES; p++) begin
      lim = (p < 6) ? limit_plan[p] : 5'($urandom_range(0, 31));
      set_search_limit(lim);
      heavy = (p == 3) || (p == 4);
      if (p == 2) hold_req = 1'b1;
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (i % 32 == 0) gaps_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 2) != 0);
        beat = make_beat(heavy);
        offer_beat(beat, 1'b0, '0);
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    // Let any stray result show up before closing
    repeat (SETTLE_CYC) @(posedge clk);
    $display("Covered %0d command beats, %0d allocates of which %0d were granted,",
             beats_total, alloc_total, grant_total);
    $display("across %0d search-limit writes with stalls on both sides.", limits_run);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
